/* src/keyword_substitution_encrypt_unit_macros.svh */
// Assertion helpers shared by the cipher unit files.
`ifndef KEYWORD_SUBSTITUTION_ENCRYPT_UNIT_MACROS_SVH
`define KEYWORD_SUBSTITUTION_ENCRYPT_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS
// Check a property on every rising edge outside reset.
`define KSENC_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("ksenc assertion failed");
// Check a property on every rising edge, reset included.
`define KSENC_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("ksenc assertion failed");
`else
`define KSENC_ASSERT(label, clk, rstn, prop)
`define KSENC_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

/* src/ksenc_pkg.sv */
package ksenc_pkg;

    localparam int LETTERS          = 26;
    localparam int LETTER_W         = $clog2(LETTERS);
    localparam int CHAR_W           = 8;
    localparam int QUEUE_DEPTH_DEF  = 4;

    localparam logic [CHAR_W-1:0] ASCII_UPPER_A = 8'h41;
    localparam logic [CHAR_W-1:0] ASCII_UPPER_Z = 8'h5A;
    localparam logic [CHAR_W-1:0] ASCII_LOWER_A = 8'h61;
    localparam logic [CHAR_W-1:0] ASCII_LOWER_Z = 8'h7A;

    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_KEY   = 2'd1,
        OP_SEAL  = 2'd2,
        OP_DATA  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_NOT_LETTER = 2'd1,
        ST_AFTER_SEAL = 2'd2
    } status_t;

    // Classified item as it sits in the queue.
    typedef struct packed {
        op_t                 op;
        logic [CHAR_W-1:0]   ch;
        logic                is_letter;
        logic                is_lower;
        logic [LETTER_W-1:0] idx;
    } item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_stat_t;

endpackage

/* src/keyword_substitution_encrypt_unit.sv */
// An accepted transaction is queued; its result is registered when it leaves the head.
// A seal or data transaction that finds the alphabet unsealed first has the back end
// walk all 26 letters one per cycle, then return to its dispatch state. Otherwise, the
// single back-end dispatch takes one transaction per cycle unless the result stalls.
// Reset (aresetn low, synchronous): queue empty, key cleared, no result pending.
module keyword_substitution_encrypt_unit #(
    parameter int QUEUE_DEPTH = ksenc_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    // Input channel
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [ksenc_pkg::CHAR_W-1:0] s_tdata,   // [7:0] char_in
    input  logic [1:0]                   s_tuser,   // [1:0] opcode
    // Result channel
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [ksenc_pkg::CHAR_W-1:0] m_tdata,   // [7:0] char_out
    output logic [1:0]                   m_tuser    // [1:0] status
);
    import ksenc_pkg::*;

    // Front end: classify each accepted transaction (letter, case, index) and
    // push it into the queue. Ready drops only when the queue is full.
    logic        push;
    item_t       push_item;
    item_t       head_item;
    logic        pop;
    queue_stat_t q_stat;

    ksenc_front u_front (
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .q_stat    (q_stat),
        .push      (push),
        .push_item (push_item)
    );

    // Short queue: decouples intake from the back end while it walks the
    // alphabet or waits on a stalled result.
    ksenc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head_item (head_item),
        .q_stat    (q_stat)
    );

    // Back end: hold the key state and cipher alphabet, run the seal walk,
    // substitute data letters and drive the result register.
    ksenc_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .head_item (head_item),
        .q_stat    (q_stat),
        .pop       (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

/* src/ksenc_front.sv */
module ksenc_front (
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [ksenc_pkg::CHAR_W-1:0]    s_tdata,
    input  logic [1:0]                      s_tuser,
    input  ksenc_pkg::queue_stat_t          q_stat,
    output logic                            push,
    output ksenc_pkg::item_t                push_item
);
    import ksenc_pkg::*;

    logic is_upper;
    logic is_lower;

    assign is_upper = (s_tdata >= ASCII_UPPER_A) && (s_tdata <= ASCII_UPPER_Z);
    assign is_lower = (s_tdata >= ASCII_LOWER_A) && (s_tdata <= ASCII_LOWER_Z);

    assign s_tready = !q_stat.full;
    assign push     = s_tvalid && !q_stat.full;

    always_comb begin
        push_item.op        = op_t'(s_tuser);
        push_item.ch        = s_tdata;
        push_item.is_letter = is_upper || is_lower;
        push_item.is_lower  = is_lower;
        if (is_lower) begin
            push_item.idx = LETTER_W'(s_tdata - ASCII_LOWER_A);
        end else begin
            push_item.idx = LETTER_W'(s_tdata - ASCII_UPPER_A);
        end
    end

endmodule

/* src/ksenc_queue.sv */
`include "keyword_substitution_encrypt_unit_macros.svh"

module ksenc_queue #(
    parameter int DEPTH = ksenc_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   push,
    input  ksenc_pkg::item_t       push_item,
    input  logic                   pop,
    output ksenc_pkg::item_t       head_item,
    output ksenc_pkg::queue_stat_t q_stat
);
    import ksenc_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    item_t            mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign q_stat.full  = (count_reg == CNT_W'(DEPTH));
    assign q_stat.empty = (count_reg == '0);
    assign head_item    = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
            if (push) begin
                mem_reg[wr_ptr_reg] <= push_item;
            end
        end
    end

    `KSENC_ASSERT(a_no_push_full, aclk, aresetn, push |-> !q_stat.full)
    `KSENC_ASSERT(a_no_pop_empty, aclk, aresetn, pop |-> !q_stat.empty)
    `KSENC_ASSERT(a_count_bound, aclk, aresetn, count_reg <= CNT_W'(DEPTH))

endmodule

/* src/ksenc_back.sv */
`include "keyword_substitution_encrypt_unit_macros.svh"

module ksenc_back (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  ksenc_pkg::item_t             head_item,
    input  ksenc_pkg::queue_stat_t       q_stat,
    output logic                         pop,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [ksenc_pkg::CHAR_W-1:0] m_tdata,
    output logic [1:0]                   m_tuser
);
    import ksenc_pkg::*;

    typedef enum logic {
        BK_IDLE,
        BK_SEAL
    } back_state_t;

    back_state_t         state_reg, state_next;
    logic [LETTER_W-1:0] walk_reg, walk_next;
    logic [LETTER_W-1:0] alphabet_reg [LETTERS];
    logic [LETTERS-1:0]  used_reg, used_next;
    logic [LETTER_W-1:0] fill_reg, fill_next;
    logic                sealed_reg, sealed_next;
    logic                out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0]   out_char_reg, out_char_next;
    status_t             out_status_reg, out_status_next;

    logic                wr_en;
    logic [LETTER_W-1:0] wr_data;
    logic                out_free;
    logic                has_room;
    logic [CHAR_W-1:0]   case_base;

    assign out_free  = !out_valid_reg || m_tready;
    assign has_room  = fill_reg < LETTER_W'(LETTERS);
    assign case_base = head_item.is_lower ? ASCII_LOWER_A : ASCII_UPPER_A;

    always_comb begin
        state_next      = state_reg;
        walk_next       = walk_reg;
        used_next       = used_reg;
        fill_next       = fill_reg;
        sealed_next     = sealed_reg;
        out_valid_next  = out_valid_reg;
        out_char_next   = out_char_reg;
        out_status_next = out_status_reg;
        wr_en           = 1'b0;
        wr_data         = head_item.idx;
        pop             = 1'b0;

        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            BK_IDLE: begin
                if (!q_stat.empty && out_free) begin
                    if ((head_item.op == OP_SEAL || head_item.op == OP_DATA) && !sealed_reg) begin
                        // Fill the alphabet first; the item stays at the queue head.
                        state_next = BK_SEAL;
                        walk_next  = '0;
                    end else begin
                        pop             = 1'b1;
                        out_valid_next  = 1'b1;
                        out_char_next   = '0;
                        out_status_next = ST_OK;
                        case (head_item.op)
                            OP_CLEAR: begin
                                used_next   = '0;
                                fill_next   = '0;
                                sealed_next = 1'b0;
                            end
                            OP_KEY: begin
                                if (sealed_reg) begin
                                    out_status_next = ST_AFTER_SEAL;
                                end else if (!head_item.is_letter) begin
                                    out_status_next = ST_NOT_LETTER;
                                end else if (!used_reg[head_item.idx] && has_room) begin
                                    used_next[head_item.idx] = 1'b1;
                                    wr_en     = 1'b1;
                                    wr_data   = head_item.idx;
                                    fill_next = fill_reg + 1'b1;
                                end
                            end
                            OP_DATA: begin
                                if (head_item.is_letter) begin
                                    out_char_next = case_base +
                                        CHAR_W'(alphabet_reg[head_item.idx]);
                                end else begin
                                    out_char_next = head_item.ch;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
            end
            BK_SEAL: begin
                // Append each unused letter in A..Z order.
                if (!used_reg[walk_reg] && has_room) begin
                    wr_en     = 1'b1;
                    wr_data   = walk_reg;
                    fill_next = fill_reg + 1'b1;
                end
                if (walk_reg == LETTER_W'(LETTERS - 1)) begin
                    sealed_next = 1'b1;
                    walk_next   = '0;
                    state_next  = BK_IDLE;
                end else begin
                    walk_next = walk_reg + 1'b1;
                end
            end
            default: begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= BK_IDLE;
            walk_reg       <= '0;
            used_reg       <= '0;
            fill_reg       <= '0;
            sealed_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_char_reg   <= '0;
            out_status_reg <= ST_OK;
        end else begin
            state_reg      <= state_next;
            walk_reg       <= walk_next;
            used_reg       <= used_next;
            fill_reg       <= fill_next;
            sealed_reg     <= sealed_next;
            out_valid_reg  <= out_valid_next;
            out_char_reg   <= out_char_next;
            out_status_reg <= out_status_next;
            if (wr_en) begin
                alphabet_reg[fill_reg] <= wr_data;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_char_reg;
    assign m_tuser  = out_status_reg;

    `KSENC_ASSERT(a_fill_bound, aclk, aresetn, fill_reg <= LETTER_W'(LETTERS))
    `KSENC_ASSERT(a_sealed_full, aclk, aresetn, sealed_reg |-> fill_reg == LETTER_W'(LETTERS))
    `KSENC_ASSERT(a_used_matches_fill, aclk, aresetn,
        (state_reg == BK_IDLE && !sealed_reg) |-> $countones(used_reg) == int'(fill_reg))
    `KSENC_ASSERT(a_no_pop_in_walk, aclk, aresetn, (state_reg == BK_SEAL) |-> !pop)

endmodule

/* test/tb_keyword_substitution_encrypt_unit.sv */
module tb_keyword_substitution_encrypt_unit;
    import ksenc_pkg::*;

    // No transaction on either channel for this many cycles ends the run.
    localparam int STALL_LIMIT  = 5000;
    // Seal walk plus pipeline, with margin, before the final verdict.
    localparam int SETTLE_CYCLES = 60;
    localparam int REPORT_MAX    = 10;

    typedef struct {
        logic [CHAR_W-1:0] ch;
        status_t           st;
    } cipher_result_t;

    logic              aclk     = 1'b0;
    logic              aresetn  = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [CHAR_W-1:0] s_tdata  = '0;   // [7:0] char_in
    logic [1:0]        s_tuser  = OP_CLEAR; // [1:0] opcode
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [CHAR_W-1:0] m_tdata;         // [7:0] char_out
    logic [1:0]        m_tuser;         // [1:0] status

    keyword_substitution_encrypt_unit uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #5 aclk = ~aclk;

    // Predicted cipher state.
    logic [LETTER_W-1:0] subst_table [LETTERS];
    logic [LETTERS-1:0]  key_used    = '0;
    int                  slots_filled = 0;
    logic                key_sealed  = 1'b0;

    cipher_result_t cipher_results_q [$];

    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    int mismatch_count = 0;
    int stall_cycles   = 0;

    function automatic int letter_of(input logic [CHAR_W-1:0] c);
        if (c >= ASCII_UPPER_A && c <= ASCII_UPPER_Z) return int'(c - ASCII_UPPER_A);
        if (c >= ASCII_LOWER_A && c <= ASCII_LOWER_Z) return int'(c - ASCII_LOWER_A);
        return -1;
    endfunction

    // Fill the open slots with the unused letters in alphabet order.
    function void seal_key();
        if (key_sealed) return;
        for (int j = 0; j < LETTERS; j++) begin
            if (!key_used[j] && slots_filled < LETTERS) begin
                subst_table[slots_filled] = LETTER_W'(j);
                slots_filled++;
            end
        end
        key_sealed = 1'b1;
    endfunction

    function void predict_cipher_item(input op_t op, input logic [CHAR_W-1:0] ch);
        cipher_result_t exp_r;
        int             idx;
        exp_r.ch = '0;
        exp_r.st = ST_OK;
        case (op)
            OP_CLEAR: begin
                key_used     = '0;
                slots_filled = 0;
                key_sealed   = 1'b0;
            end
            OP_KEY: begin
                idx = letter_of(ch);
                if (key_sealed) begin
                    exp_r.st = ST_AFTER_SEAL;
                end else if (idx < 0) begin
                    exp_r.st = ST_NOT_LETTER;
                end else if (!key_used[idx] && slots_filled < LETTERS) begin
                    key_used[idx]             = 1'b1;
                    subst_table[slots_filled] = LETTER_W'(idx);
                    slots_filled++;
                end
            end
            OP_SEAL: seal_key();
            default: begin
                seal_key();
                idx      = letter_of(ch);
                exp_r.ch = ch;
                if (idx >= 0)
                    exp_r.ch = ((ch >= ASCII_LOWER_A) ? ASCII_LOWER_A : ASCII_UPPER_A)
                               + CHAR_W'(subst_table[idx]);
            end
        endcase
        cipher_results_q.push_back(exp_r);
    endfunction

    function automatic logic [CHAR_W-1:0] random_letter();
        logic [CHAR_W-1:0] base;
        base = $urandom_range(1) ? ASCII_LOWER_A : ASCII_UPPER_A;
        return base + CHAR_W'($urandom_range(LETTERS-1));
    endfunction

    // Present one transaction, hold it until accepted, then predict its result.
    task automatic send_item(input op_t op, input logic [CHAR_W-1:0] ch);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= ch;
        s_tuser  <= op;
        do @(posedge aclk); while (!s_tready);
        predict_cipher_item(op, ch);
    endtask

    // Hold off the sender until every predicted result has come back.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (cipher_results_q.size() != 0) @(posedge aclk);
    endtask

    task automatic test_directed_cases();
        // Data on an empty, unsealed key seals it to the identity alphabet.
        send_item(OP_DATA, ASCII_UPPER_A);
        send_item(OP_CLEAR, 8'hFF);
        send_item(OP_KEY, ASCII_LOWER_Z);
        send_item(OP_KEY, ASCII_UPPER_Z);      // repeated letter, other case
        send_item(OP_KEY, ASCII_UPPER_A);
        send_item(OP_KEY, ASCII_UPPER_A - 8'd1);  // just outside each letter range
        send_item(OP_KEY, ASCII_UPPER_Z + 8'd1);
        send_item(OP_KEY, ASCII_LOWER_A - 8'd1);
        send_item(OP_KEY, ASCII_LOWER_Z + 8'd1);
        send_item(OP_KEY, 8'h00);
        send_item(OP_KEY, 8'hFF);
        send_item(OP_SEAL, 8'hAA);
        send_item(OP_SEAL, 8'h55);             // already sealed
        send_item(OP_KEY, ASCII_LOWER_A + 8'd1);  // letter after seal
        send_item(OP_KEY, 8'h31);              // non-letter after seal
        send_item(OP_DATA, ASCII_LOWER_A);
        send_item(OP_DATA, ASCII_LOWER_Z);
        send_item(OP_DATA, ASCII_UPPER_Z);
        send_item(OP_DATA, ASCII_UPPER_A + 8'd12);
        send_item(OP_DATA, ASCII_UPPER_A - 8'd1);
        send_item(OP_DATA, ASCII_LOWER_Z + 8'd1);
        send_item(OP_DATA, 8'h00);
        send_item(OP_DATA, 8'hFF);
        send_item(OP_CLEAR, 8'h00);
    endtask

    // Fill all 26 slots from the key, then read every slot in both cases.
    task automatic test_full_alphabet_key();
        int order [LETTERS];
        int i;
        int j;
        int t;
        for (int round = 0; round < 2; round++) begin
            send_item(OP_CLEAR, 8'($urandom_range(255)));
            for (i = 0; i < LETTERS; i++) order[i] = i;
            for (i = LETTERS - 1; i > 0; i--) begin
                j        = $urandom_range(i);
                t        = order[i];
                order[i] = order[j];
                order[j] = t;
            end
            for (i = 0; i < LETTERS; i++)
                send_item(OP_KEY, ($urandom_range(1) ? ASCII_LOWER_A : ASCII_UPPER_A)
                                  + CHAR_W'(order[i]));
            send_item(OP_KEY, random_letter());
            // First round seals explicitly, second lets the first data item do it.
            if (round == 0) send_item(OP_SEAL, 8'($urandom_range(255)));
            for (i = 0; i < LETTERS; i++) begin
                send_item(OP_DATA, ASCII_UPPER_A + CHAR_W'(i));
                send_item(OP_DATA, ASCII_LOWER_A + CHAR_W'(i));
            end
        end
    endtask

    // Mostly well-formed key sessions with random content, some noise.
    task automatic test_random_sessions(input int n_items);
        int sent;
        int n_key;
        int n_data;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(99) < 8) begin
                send_item(op_t'($urandom_range(3)), 8'($urandom_range(255)));
                sent++;
            end else begin
                if ($urandom_range(9) != 0) begin
                    send_item(OP_CLEAR, 8'($urandom_range(255)));
                    sent++;
                end
                n_key = $urandom_range(30);
                for (int k = 0; k < n_key; k++) begin
                    send_item(OP_KEY, ($urandom_range(9) != 0) ? random_letter()
                                                              : 8'($urandom_range(255)));
                    sent++;
                end
                if ($urandom_range(1)) begin
                    send_item(OP_SEAL, 8'($urandom_range(255)));
                    sent++;
                end
                n_data = $urandom_range(1, 12);
                for (int k = 0; k < n_data; k++) begin
                    send_item(OP_DATA, ($urandom_range(99) < 85) ? random_letter()
                                                                : 8'($urandom_range(255)));
                    sent++;
                    if ($urandom_range(19) == 0) begin
                        send_item(OP_KEY, 8'($urandom_range(255)));
                        sent++;
                    end
                end
            end
        end
    endtask

    // Stall the result channel at the configured rate.
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // Compare every accepted result with the oldest prediction.
    always @(posedge aclk) begin
        cipher_result_t exp_r;
        if (aresetn && m_tvalid && m_tready) begin
            if (cipher_results_q.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_MAX)
                    $display("unexpected result: char_out=%0h status=%0d", m_tdata, m_tuser);
            end else begin
                exp_r = cipher_results_q.pop_front();
                if (m_tdata !== exp_r.ch || m_tuser !== exp_r.st) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_MAX)
                        $display("mismatch: char_out exp %0h got %0h, status exp %0d got %0d",
                                 exp_r.ch, m_tdata, exp_r.st, m_tuser);
                end
            end
        end
    end

    // Watchdog: end the run when no transaction moves for too long.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed_cases();
        drain_results();

        src_idle_pct   = 34;
        sink_stall_pct = 34;
        test_full_alphabet_key();
        drain_results();

        // Idle phases: none, sender only, receiver only, both.
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 69; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 69; end
                default: begin src_idle_pct = 34; sink_stall_pct = 34; end
            endcase
            test_random_sessions(110);
            drain_results();
        end

        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (cipher_results_q.size() != 0) mismatch_count++;
        if (mismatch_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

/* keyword_substitution_encrypt_unit.f */
+incdir+src
src/ksenc_pkg.sv
src/ksenc_front.sv
src/ksenc_queue.sv
src/ksenc_back.sv
src/keyword_substitution_encrypt_unit.sv
test/tb_keyword_substitution_encrypt_unit.sv
